// ----- rtl/core/spv_pkg.sv -----
// ----------------------------------------------------------------------------
// spv_pkg
// Shared types and constants for the Schnorr proof verifier: command and
// status records of the modular arithmetic unit, operation codes, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package spv_pkg;

	// datapath width default
	localparam int DEF_WIDTH = 32;

	// configuration register reset values
	localparam int unsigned RST_MODULUS   = 23;
	localparam int unsigned RST_GENERATOR = 5;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 1'd1;

	// arithmetic unit operations
	localparam logic OP_MUL = 1'b0;   // (a * b) mod m, a already reduced
	localparam logic OP_RED = 1'b1;   // b mod m

	typedef struct packed {
		logic go;
		logic op;
	} spv_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} spv_stat_t;

endpackage

// ----- rtl/core/spv_mulmod_unit.sv -----
// ----------------------------------------------------------------------------
// spv_mulmod_unit
// Shared modular arithmetic unit. Multiplies by shift-add, one multiplier
// bit per cycle, or reduces a value modulo m by restoring division, one
// dividend bit per cycle. Pulses done for one cycle when the result is ready.
// ----------------------------------------------------------------------------
module spv_mulmod_unit #(
	parameter int WIDTH = spv_pkg::DEF_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spv_pkg::spv_cmd_t cmd,
	input  logic [WIDTH-1:0]  opa,
	input  logic [WIDTH-1:0]  opb,
	input  logic [WIDTH-1:0]  m,
	output spv_pkg::spv_stat_t stat,
	output logic [WIDTH-1:0]  result
);
	import spv_pkg::*;

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic             busy_q;
	logic             done_q;
	logic             op_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;

	logic [WIDTH-1:0] acc_add;
	logic [WIDTH-1:0] a_dbl;
	logic [WIDTH:0]   red_v;
	logic [WIDTH:0]   red_sub;
	logic [WIDTH-1:0] red_nxt;

	// (x + y) mod mm for x, y below mm, without overflow
	function automatic logic [WIDTH-1:0] add_mod(
		input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y,
		input logic [WIDTH-1:0] mm
	);
		logic [WIDTH-1:0] room;
		room = mm - y;
		return (x >= room) ? (x - room) : (x + y);
	endfunction

	// multiply step: add and double in parallel
	assign acc_add = add_mod(acc_q, a_q, m);
	assign a_dbl   = add_mod(a_q, a_q, m);

	// reduce step: shift in next dividend bit, subtract once if needed
	assign red_v   = {acc_q, b_q[WIDTH-1]};
	assign red_sub = red_v - {1'b0, m};
	assign red_nxt = (red_v >= {1'b0, m}) ? red_sub[WIDTH-1:0] : red_v[WIDTH-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (op_q == OP_MUL) begin
					if (b_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(WIDTH - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.go && !busy_q) begin
			acc_q <= '0;
			a_q   <= opa;
			b_q   <= opb;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				if (b_q != '0) begin
					if (b_q[0])
						acc_q <= acc_add;
					a_q <= a_dbl;
					b_q <= b_q >> 1;
				end
			end else begin
				acc_q <= red_nxt;
				b_q   <= b_q << 1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = acc_q;

	// a new operation only starts on an idle unit
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> !busy_q)
		else $error("unit started while busy");

	// completion follows work and leaves the unit idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("done without preceding operation");

	// every result is fully reduced
	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && m != '0 && $stable(m)) |-> (acc_q < m))
		else $error("unit result not reduced");

endmodule

// ----- rtl/core/spv_seq.sv -----
// ----------------------------------------------------------------------------
// spv_seq
// Sequencer of the verifier. Reduces g, y and t, runs right-to-left
// square-and-multiply for g^s and y^c on the shared unit, multiplies t into
// the right side and compares both sides.
// ----------------------------------------------------------------------------
module spv_seq #(
	parameter int WIDTH = spv_pkg::DEF_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [WIDTH-1:0]   pub_key,
	input  logic [WIDTH-1:0]   commit_value,
	input  logic [WIDTH-1:0]   challenge_exp,
	input  logic [WIDTH-1:0]   response_exp,
	input  logic [WIDTH-1:0]   modulus,
	input  logic [WIDTH-1:0]   group_generator,
	output logic               done,
	output logic               proof_valid,
	output spv_pkg::spv_cmd_t  cmd,
	output logic [WIDTH-1:0]   opa,
	output logic [WIDTH-1:0]   opb,
	input  spv_pkg::spv_stat_t stat,
	input  logic [WIDTH-1:0]   result
);
	import spv_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RED_G = 3'd1;
	localparam logic [2:0] S_RED_Y = 3'd2;
	localparam logic [2:0] S_RED_T = 3'd3;
	localparam logic [2:0] S_STEP  = 3'd4;
	localparam logic [2:0] S_MUL   = 3'd5;
	localparam logic [2:0] S_SQ    = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0]       state_q;
	logic             pass_q;      // 0: left side g^s, 1: right side y^c
	logic             done_q;
	logic             valid_q;
	spv_cmd_t         cmd_q;
	logic [WIDTH-1:0] opa_q;
	logic [WIDTH-1:0] opb_q;
	logic [WIDTH-1:0] y_q;
	logic [WIDTH-1:0] t_q;
	logic [WIDTH-1:0] c_q;
	logic [WIDTH-1:0] s_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] sq_q;
	logic [WIDTH-1:0] lhs_q;

	// control: state, pass, unit command, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= 1'b0;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
			cmd_q   <= '0;
		end else begin
			done_q   <= 1'b0;
			cmd_q.go <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (modulus == '0) begin
							done_q  <= 1'b1;
							valid_q <= 1'b0;
						end else begin
							cmd_q   <= '{go: 1'b1, op: OP_RED};
							state_q <= S_RED_G;
						end
					end
				end
				S_RED_G: begin
					if (stat.done) begin
						cmd_q   <= '{go: 1'b1, op: OP_RED};
						state_q <= S_RED_Y;
					end
				end
				S_RED_Y: begin
					if (stat.done) begin
						cmd_q   <= '{go: 1'b1, op: OP_RED};
						state_q <= S_RED_T;
					end
				end
				S_RED_T: begin
					if (stat.done) begin
						pass_q  <= 1'b0;
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (e_q == '0) begin
						if (!pass_q) begin
							pass_q <= 1'b1;
						end else begin
							cmd_q   <= '{go: 1'b1, op: OP_MUL};
							state_q <= S_FIN;
						end
					end else begin
						cmd_q   <= '{go: 1'b1, op: OP_MUL};
						state_q <= e_q[0] ? S_MUL : S_SQ;
					end
				end
				S_MUL: begin
					if (stat.done) begin
						if (e_q[WIDTH-1:1] != '0) begin
							cmd_q   <= '{go: 1'b1, op: OP_MUL};
							state_q <= S_SQ;
						end else begin
							state_q <= S_STEP;
						end
					end
				end
				S_SQ: begin
					if (stat.done)
						state_q <= S_STEP;
				end
				S_FIN: begin
					if (stat.done) begin
						done_q  <= 1'b1;
						valid_q <= (lhs_q == result);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: operands, exponent, accumulator and square
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					y_q   <= pub_key;
					t_q   <= commit_value;
					c_q   <= challenge_exp;
					s_q   <= response_exp;
					opb_q <= group_generator;
				end
			end
			S_RED_G: begin
				if (stat.done) begin
					sq_q  <= result;
					opb_q <= y_q;
				end
			end
			S_RED_Y: begin
				if (stat.done) begin
					y_q   <= result;
					opb_q <= t_q;
				end
			end
			S_RED_T: begin
				if (stat.done) begin
					t_q   <= result;
					acc_q <= WIDTH'(1);
					e_q   <= s_q;
				end
			end
			S_STEP: begin
				if (e_q == '0) begin
					if (!pass_q) begin
						lhs_q <= acc_q;
						acc_q <= WIDTH'(1);
						sq_q  <= y_q;
						e_q   <= c_q;
					end else begin
						opa_q <= t_q;
						opb_q <= acc_q;
					end
				end else if (e_q[0]) begin
					opa_q <= sq_q;
					opb_q <= acc_q;
				end else begin
					opa_q <= sq_q;
					opb_q <= sq_q;
				end
			end
			S_MUL: begin
				if (stat.done) begin
					acc_q <= result;
					if (e_q[WIDTH-1:1] != '0) begin
						opa_q <= sq_q;
						opb_q <= sq_q;
					end else begin
						e_q <= '0;
					end
				end
			end
			S_SQ: begin
				if (stat.done) begin
					sq_q <= result;
					e_q  <= e_q >> 1;
				end
			end
			default: ;
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign proof_valid = valid_q;
	assign cmd         = cmd_q;
	assign opa         = opa_q;
	assign opb         = opb_q;

	// a result comes from the final multiply or from a zero modulus start
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_FIN) || ($past(state_q) == S_IDLE && $past(start)))
		else $error("result strobe without a transaction");

	// the final multiply only follows the right side exponentiation
	a_fin_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> pass_q)
		else $error("final multiply before right side");

	// leaving idle always takes a new transaction
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("sequencer left idle without start");

	// the unit is never commanded while it works
	a_cmd_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_q.go |-> !stat.busy)
		else $error("command issued to busy unit");

endmodule

// ----- rtl/core/schnorr_proof_verify_top.sv -----
// ----------------------------------------------------------------------------
// schnorr_proof_verify_top
// Schnorr identification verifier: checks g^s mod p == t * y^c mod p.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: drive pub_key, commit_value, challenge_exp and
//   response_exp and raise start while busy is low; the fields are captured
//   at that edge. busy stays high until the verdict is out.
//   Result transaction: done is high for exactly one cycle with proof_valid.
//   The receiver cannot stall; the result is shown once and dropped.
//   Configuration: write modulus (index 0) and group_generator (index 1)
//   through cfg_wr_en / cfg_index / cfg_data while the block is idle.
//   A zero modulus gives proof_valid low in the cycle after the accepting
//   edge; busy stays low for it.
// Arithmetic: one shared modular unit does all arithmetic, one bit
//   per cycle. Three reductions come first; every modular multiply works
//   through the bits of its multiplier, and each exponent bit costs a
//   pass through the step state plus up to two multiplies. A final
//   multiply of t into the right side ends the run. A new start is
//   taken while done is shown.
// Reset: arst_n clears control; modulus returns to 23, generator to 5.
// ----------------------------------------------------------------------------
module schnorr_proof_verify_top #(
	parameter int WIDTH = spv_pkg::DEF_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [WIDTH-1:0]              pub_key,
	input  logic [WIDTH-1:0]              commit_value,
	input  logic [WIDTH-1:0]              challenge_exp,
	input  logic [WIDTH-1:0]              response_exp,
	output logic                          done,
	output logic                          proof_valid,
	input  logic                          cfg_wr_en,
	input  logic [spv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [WIDTH-1:0]              cfg_data
);
	import spv_pkg::*;

	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] generator_q;
	spv_cmd_t         cmd;
	spv_stat_t        stat;
	logic [WIDTH-1:0] opa;
	logic [WIDTH-1:0] opb;
	logic [WIDTH-1:0] result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= WIDTH'(RST_MODULUS);
			generator_q <= WIDTH'(RST_GENERATOR);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MODULUS:   modulus_q   <= cfg_data;
				CFG_GENERATOR: generator_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	spv_seq #(.WIDTH(WIDTH)) u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.pub_key         (pub_key),
		.commit_value    (commit_value),
		.challenge_exp   (challenge_exp),
		.response_exp    (response_exp),
		.modulus         (modulus_q),
		.group_generator (generator_q),
		.done            (done),
		.proof_valid     (proof_valid),
		.cmd             (cmd),
		.opa             (opa),
		.opb             (opb),
		.stat            (stat),
		.result          (result)
	);

	// shared modular arithmetic unit
	spv_mulmod_unit #(.WIDTH(WIDTH)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (opa),
		.opb    (opb),
		.m      (modulus_q),
		.stat   (stat),
		.result (result)
	);

	// configuration must hold while a transaction is in flight
	a_cfg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_wr_en)
		else $error("configuration written during a transaction");

	// a zero modulus never reaches the arithmetic unit
	a_no_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> (modulus_q != '0))
		else $error("arithmetic started with zero modulus");

	// result strobe never overlaps a busy sequencer
	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		(done && busy) |-> 1'b0)
		else $error("result strobe while busy");

endmodule

// ----- tb/schnorr_proof_verify_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// schnorr_proof_verify_top_tb
// Self-checking bench for the Schnorr proof verifier. A local model of the
// modular exponentiations predicts proof_valid for every accepted
// transaction. Directed checks cover the reset settings, degenerate moduli,
// unreduced operands and extreme fields. Random traffic then runs mostly
// well-formed proofs, with corrupted and noise transactions mixed in, under
// several modulus and generator settings.
// ----------------------------------------------------------------------------
module schnorr_proof_verify_top_tb;
	import spv_pkg::*;

	localparam int W = 32;
	localparam logic [W-1:0] ALL_ONES = '1;
	localparam logic [W-1:0] PRIME_MAX = 32'd4294967291;   // largest 32-bit prime

	typedef struct packed {
		logic [W-1:0] pub_key;
		logic [W-1:0] commit_value;
		logic [W-1:0] challenge_exp;
		logic [W-1:0] response_exp;
	} proof_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         start = 1'b0;
	logic         busy;
	logic [W-1:0] pub_key = '0;
	logic [W-1:0] commit_value = '0;
	logic [W-1:0] challenge_exp = '0;
	logic [W-1:0] response_exp = '0;
	logic         done;
	logic         proof_valid;
	logic         cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MODULUS;
	logic [W-1:0] cfg_data = '0;

	// local copy of the configuration registers, reset values
	logic [W-1:0] cur_modulus = RST_MODULUS;
	logic [W-1:0] cur_generator = RST_GENERATOR;

	logic verdict_q[$];
	int unsigned max_gap = 15;
	int unsigned sent_cnt = 0;
	int unsigned checked_cnt = 0;
	int unsigned valid_cnt = 0;
	int unsigned setting_cnt = 1;
	int unsigned mismatch_cnt = 0;

	schnorr_proof_verify_top #(.WIDTH(W)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.pub_key       (pub_key),
		.commit_value  (commit_value),
		.challenge_exp (challenge_exp),
		.response_exp  (response_exp),
		.done          (done),
		.proof_valid   (proof_valid),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// exact modular product, m > 0
	function automatic logic [63:0] modmul(logic [63:0] a, logic [63:0] b, logic [63:0] m);
		return ((a % m) * (b % m)) % m;
	endfunction

	// base^e mod m; a zero exponent gives 1 without reduction
	function automatic logic [63:0] modexp(logic [63:0] base, logic [W-1:0] e,
			logic [63:0] m);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1;
		sq = base % m;
		for (int i = 0; i < W; i++) begin
			if (e[i])
				acc = modmul(acc, sq, m);
			sq = modmul(sq, sq, m);
		end
		return acc;
	endfunction

	// g^s == t * y^c under the current settings; zero modulus never verifies
	function automatic logic predict_proof_valid(proof_t p);
		logic [63:0] lhs;
		logic [63:0] rhs;
		if (cur_modulus == '0)
			return 1'b0;
		lhs = modexp(cur_generator, p.response_exp, cur_modulus);
		rhs = modmul(p.commit_value, modexp(p.pub_key, p.challenge_exp, cur_modulus),
			cur_modulus);
		return lhs == rhs;
	endfunction

	// honest proof from secret x, nonce k and challenge c; s = k + c*x must fit
	function automatic proof_t build_proof(logic [63:0] x, logic [63:0] k, logic [63:0] c);
		proof_t p;
		logic [63:0] y;
		logic [63:0] t;
		logic [63:0] s;
		y = modexp(cur_generator, x[W-1:0], cur_modulus);
		t = modexp(cur_generator, k[W-1:0], cur_modulus);
		s = k + c * x;
		// leave some operands unreduced
		if ($urandom_range(0, 3) == 0 && y + cur_modulus <= ALL_ONES)
			y = y + cur_modulus;
		if ($urandom_range(0, 3) == 0 && t + cur_modulus <= ALL_ONES)
			t = t + cur_modulus;
		p.pub_key = y[W-1:0];
		p.commit_value = t[W-1:0];
		p.challenge_exp = c[W-1:0];
		p.response_exp = s[W-1:0];
		return p;
	endfunction

	// random honest proof; operand sizes vary so s reaches every bit
	function automatic proof_t random_proof();
		logic [63:0] k;
		logic [63:0] c;
		logic [63:0] x;
		k = $urandom >> $urandom_range(0, W - 1);
		c = $urandom >> $urandom_range(0, W - 1);
		if (c == 0)
			x = $urandom;
		else
			x = $urandom_range(0, (64'(ALL_ONES) - k) / c);
		return build_proof(x, k, c);
	endfunction

	// send one transaction; start stays high afterwards for back-to-back issue
	task automatic send_proof(proof_t p);
		int unsigned gap;
		gap = $urandom_range(0, max_gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		pub_key <= p.pub_key;
		commit_value <= p.commit_value;
		challenge_exp <= p.challenge_exp;
		response_exp <= p.response_exp;
		do @(posedge clk); while (busy !== 1'b0);
		verdict_q.push_back(predict_proof_valid(p));
		sent_cnt++;
	endtask

	task automatic send_fields(logic [W-1:0] y, logic [W-1:0] t, logic [W-1:0] c,
			logic [W-1:0] s);
		send_proof('{y, t, c, s});
	endtask

	// drop start and wait until every expected verdict is out and the block is idle
	task automatic drain();
		start <= 1'b0;
		while (verdict_q.size() != 0 || busy !== 1'b0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// write modulus and generator while idle
	task automatic write_config(logic [W-1:0] m, logic [W-1:0] g);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_MODULUS;
		cfg_data <= m;
		@(posedge clk);
		cfg_index <= CFG_GENERATOR;
		cfg_data <= g;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_modulus = m;
		cur_generator = g;
		setting_cnt++;
		@(posedge clk);
	endtask

	// reset settings: p = 23, g = 5
	task automatic test_reset_settings();
		proof_t p;
		send_fields('0, '0, '0, '0);
		send_fields('0, 32'd1, '0, '0);
		send_fields(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		send_proof(build_proof(6, 3, 4));
		// commitment at and above p: 23 reduces to 0, 24 to 1
		send_fields(32'd7, 32'd23, '0, '0);
		send_fields(32'd7, 32'd24, '0, '0);
		// corrupt the response of an honest proof
		p = build_proof(6, 3, 4);
		p.response_exp = p.response_exp + 1;
		send_proof(p);
	endtask

	// modulus one: only a nonzero response matches
	task automatic test_modulus_one();
		write_config(32'd1, 32'd5);
		send_fields(32'd3, 32'd9, 32'd2, '0);
		send_fields(32'd3, 32'd9, 32'd2, 32'd1);
		send_fields(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
	endtask

	// modulus zero: never valid
	task automatic test_modulus_zero();
		write_config('0, 32'd7);
		send_fields('0, 32'd1, '0, '0);
		send_fields($urandom, $urandom, $urandom, $urandom);
	endtask

	// widest modulus with generator at p, then the largest 32-bit prime
	task automatic test_wide_operands();
		write_config(ALL_ONES, ALL_ONES);
		send_fields('0, 32'd1, '0, '0);
		send_fields(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		send_proof(random_proof());
		write_config(PRIME_MAX, 32'd2);
		send_proof(build_proof(64'(ALL_ONES), 0, 1));
		send_proof(build_proof(0, 64'(ALL_ONES), 0));
		send_fields(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
	endtask

	// zero generator: g^0 = 1, any other power is 0
	task automatic test_generator_zero();
		write_config(32'd23, '0);
		send_fields(32'd4, 32'd1, '0, '0);
		send_fields(32'd4, '0, 32'd9, 32'd5);
		send_fields(32'd4, 32'd1, '0, 32'd5);
	endtask

	// random traffic: mostly honest proofs, some corrupted, some noise
	task automatic test_random_traffic(logic [W-1:0] m, logic [W-1:0] g, int n, int unsigned gap);
		proof_t p;
		int unsigned pick;
		write_config(m, g);
		max_gap = gap;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				p = random_proof();
			end else if (pick < 75) begin
				p = random_proof();
				p = p ^ (proof_t'(1) << $urandom_range(0, 4 * W - 1));
			end else begin
				p = {$urandom, $urandom, $urandom, $urandom};
				if ($urandom_range(0, 3) == 0)
					p.challenge_exp = '0;
				if ($urandom_range(0, 3) == 0)
					p.response_exp = ALL_ONES;
			end
			send_proof(p);
		end
		max_gap = 15;
	endtask

	// compare each verdict with the oldest prediction
	always @(posedge clk) begin : verdict_check
		logic expected_valid;
		if (arst_n && done === 1'b1) begin
			if (verdict_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("%0t: unexpected result, proof_valid=%b", $time, proof_valid);
			end else begin
				expected_valid = verdict_q.pop_front();
				checked_cnt++;
				if (proof_valid) valid_cnt++;
				if (proof_valid !== expected_valid) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: proof_valid expected %b actual %b", $time,
							expected_valid, proof_valid);
				end
			end
		end
	end

	// slowest correct run is about 130 transactions; allow 5x its length
	initial begin
		#30_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int unsigned wait_cycles;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_modulus_one();
		test_modulus_zero();
		test_wide_operands();
		test_generator_zero();
		test_random_traffic(($urandom | 32'h8000_0000) | 32'd3, $urandom, 25, 15);
		test_random_traffic($urandom_range(3, 255), $urandom, 20, 15);
		test_random_traffic(PRIME_MAX, $urandom, 20, 0);
		test_random_traffic($urandom_range(3, 32'hFFFF), $urandom_range(0, 32'hFFFF), 20, 15);
		test_random_traffic(RST_MODULUS, RST_GENERATOR, 20, 15);

		// wait for outstanding verdicts, then watch for stray ones
		start <= 1'b0;
		wait_cycles = 0;
		while (verdict_q.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (100) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$display("%0d expected results never arrived", verdict_q.size());
			mismatch_cnt += verdict_q.size();
		end

		$display("covered %0d transactions over %0d register settings", sent_cnt, setting_cnt);
		$display("checked %0d verdicts, %0d of them valid proofs", checked_cnt, valid_cnt);
		if (mismatch_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
